[rtl/kahan_compensated_dot_product_unit_macros.svh]
`ifndef KAHAN_COMPENSATED_DOT_PRODUCT_UNIT_MACROS_SVH
`define KAHAN_COMPENSATED_DOT_PRODUCT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define KCDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KCDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kcdp_pkg.sv]
`default_nettype none

package kcdp_pkg;

    typedef logic [2:0] t_op;

    localparam t_op OP_MUL  = 3'd0;
    localparam t_op OP_TSUB = 3'd1;
    localparam t_op OP_SADD = 3'd2;
    localparam t_op OP_DSUB = 3'd3;
    localparam t_op OP_CSUB = 3'd4;

    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

    typedef struct packed {
        logic [63:0] x_bits;
        logic [63:0] y_bits;
        logic        last_element;
    } t_item;

    // value = mant * 2^(expo - 1023 - 104), expo signed
    typedef struct packed {
        logic         valid;
        logic         sign;
        logic [13:0]  expo;
        logic [105:0] mant;
        logic         spec;
        logic [63:0]  spec_bits;
    } t_rnd_req;

    typedef struct packed {
        logic idle;
        logic item_last;
    } t_back_stat;

    function automatic logic [6:0] lzc106(input logic [105:0] m);
        logic [6:0] n;
        n = 7'd106;
        for (int i = 0; i < 106; i++) begin
            if (m[i]) n = 7'(105 - i);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[rtl/kcdp_in_if.sv]
`default_nettype none

interface kcdp_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    logic        last_element;

    modport source (output valid, output x_bits, output y_bits, output last_element,
                    input ready);
    modport sink (input valid, input x_bits, input y_bits, input last_element,
                  output ready);
endinterface

`default_nettype wire

[rtl/kcdp_out_if.sv]
`default_nettype none

interface kcdp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] dot_bits;

    modport source (output valid, output dot_bits, input ready);
    modport sink (input valid, input dot_bits, output ready);
endinterface

`default_nettype wire

[rtl/kcdp_queue.sv]
`default_nettype none

module kcdp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire kcdp_pkg::t_item              i_item,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    output kcdp_pkg::t_item                   o_item,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [$clog2(DEPTH + 1) - 1:0]    o_count
);
    import kcdp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PW - 1:0] r_wp;
    logic [PW - 1:0] r_rp;
    logic [CW - 1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/kcdp_round.sv]
`default_nettype none

module kcdp_round (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire kcdp_pkg::t_rnd_req i_req,
    output logic                    o_valid,
    output logic [63:0]             o_bits
);
    import kcdp_pkg::*;

    t_rnd_req     r_s1;

    logic         r_s2_valid;
    logic         r_s2_sign;
    logic [13:0]  r_s2_expo;
    logic [105:0] r_s2_mant;
    logic [6:0]   r_s2_lz;
    logic         r_s2_spec;
    logic [63:0]  r_s2_spec_bits;

    logic         r_s3_valid;
    logic         r_s3_sign;
    logic [13:0]  r_s3_ef;
    logic [105:0] r_s3_n;
    logic         r_s3_zero;
    logic         r_s3_spec;
    logic [63:0]  r_s3_spec_bits;

    logic         r_ov;
    logic [63:0]  r_ob;

    logic signed [13:0] lz_s;
    logic signed [13:0] expo_s;
    logic signed [13:0] sh;
    logic [13:0]        rs;
    logic [105:0]       n_n;
    logic [13:0]        n_ef;
    logic               up;
    logic [62:0]        field;
    logic [63:0]        n_bits;

    always_comb begin
        lz_s   = $signed({7'd0, r_s2_lz});
        expo_s = $signed(r_s2_expo);
        sh     = (lz_s <= expo_s) ? lz_s : expo_s;
        rs     = 14'(-sh);
        if (sh >= 0) begin
            n_n = r_s2_mant << sh[6:0];
        end else if (rs >= 14'd106) begin
            n_n = {105'd0, |r_s2_mant};
        end else begin
            n_n = (r_s2_mant >> rs[6:0])
                | {105'd0, |(r_s2_mant & ((106'd1 << rs[6:0]) - 106'd1))};
        end
        n_ef = n_n[105] ? 14'(expo_s + 14'sd1 - sh) : 14'd0;
    end

    always_comb begin
        up    = r_s3_n[52] && ((|r_s3_n[51:0]) || r_s3_n[53]);
        field = {r_s3_ef[10:0], r_s3_n[104:53]} + {62'd0, up};
        if (r_s3_spec) begin
            n_bits = r_s3_spec_bits;
        end else if (r_s3_zero) begin
            n_bits = {r_s3_sign, 63'd0};
        end else if ($signed(r_s3_ef) > 14'sd2046) begin
            n_bits = {r_s3_sign, 11'h7FF, 52'd0};
        end else begin
            n_bits = {r_s3_sign, field};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1.sign      <= i_req.sign;
        r_s1.expo      <= i_req.expo;
        r_s1.mant      <= i_req.mant;
        r_s1.spec      <= i_req.spec;
        r_s1.spec_bits <= i_req.spec_bits;

        r_s2_sign      <= r_s1.sign;
        r_s2_expo      <= r_s1.expo;
        r_s2_mant      <= r_s1.mant;
        r_s2_lz        <= lzc106(r_s1.mant);
        r_s2_spec      <= r_s1.spec;
        r_s2_spec_bits <= r_s1.spec_bits;

        r_s3_sign      <= r_s2_sign;
        r_s3_ef        <= n_ef;
        r_s3_n         <= n_n;
        r_s3_zero      <= (r_s2_mant == '0);
        r_s3_spec      <= r_s2_spec;
        r_s3_spec_bits <= r_s2_spec_bits;

        r_ob           <= n_bits;

        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_s1.valid <= i_req.valid;
            r_s2_valid <= r_s1.valid;
            r_s3_valid <= r_s2_valid;
            r_ov       <= r_s3_valid;
        end
    end

    assign o_valid = r_ov;
    assign o_bits  = r_ob;

endmodule

`default_nettype wire

[rtl/kcdp_back.sv]
`default_nettype none

module kcdp_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire kcdp_pkg::t_item      i_item,
    input  wire logic                 i_item_valid,
    output logic                      o_item_ready,
    output logic                      o_out_valid,
    output logic [63:0]               o_out_bits,
    input  wire logic                 i_out_ready,
    output kcdp_pkg::t_back_stat      o_stat
);
    import kcdp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_MULF  = 7'b0000100,
        S_ALIGN = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state       r_state;
    t_op          r_op;
    logic [63:0]  r_x;
    logic [63:0]  r_y;
    logic         r_last;
    logic [63:0]  r_sum;
    logic [63:0]  r_comp;
    logic [63:0]  r_prod;
    logic [63:0]  r_term;
    logic [63:0]  r_next;
    logic [63:0]  r_diff;
    logic [1:0]   r_k;
    logic [105:0] r_acc;

    logic         r_al_sign;
    logic         r_al_zsign;
    logic         r_al_sub;
    logic [10:0]  r_al_e;
    logic [105:0] r_al_ml;
    logic [105:0] r_al_ms;
    logic         r_al_spec;
    logic [63:0]  r_al_spec_bits;

    logic         r_ov;
    logic [63:0]  r_ob;

    t_rnd_req     rnd_req;
    logic         rnd_valid;
    logic [63:0]  rnd_bits;

    // multiplier operands
    logic [52:0]  ma;
    logic [52:0]  mb;
    logic [26:0]  pa;
    logic [26:0]  pb;
    logic [53:0]  pp;
    logic [6:0]   pshift;
    logic         x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
    logic [10:0]  xe, ye;

    // adder operands
    logic [63:0]  opa;
    logic [63:0]  opb;
    logic         sub_op;
    logic [63:0]  bb;
    logic         swap;
    logic [63:0]  lg;
    logic [63:0]  sm;
    logic         a_nan, b_nan, a_inf, b_inf;
    logic [10:0]  el, es, dd;
    logic [105:0] ms_full;
    logic [105:0] ms_al;
    logic [105:0] add_m;
    logic [63:0]  emit_bits;

    kcdp_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rnd_req),
        .o_valid (rnd_valid),
        .o_bits  (rnd_bits)
    );

    always_comb begin
        ma     = {|r_x[62:52], r_x[51:0]};
        mb     = {|r_y[62:52], r_y[51:0]};
        pa     = r_k[0] ? {1'b0, ma[52:27]} : ma[26:0];
        pb     = r_k[1] ? {1'b0, mb[52:27]} : mb[26:0];
        pp     = pa * pb;
        pshift = 7'((r_k[0] ? 27 : 0) + (r_k[1] ? 27 : 0));
        xe     = (r_x[62:52] == '0) ? 11'd1 : r_x[62:52];
        ye     = (r_y[62:52] == '0) ? 11'd1 : r_y[62:52];
        x_nan  = (&r_x[62:52]) && (|r_x[51:0]);
        y_nan  = (&r_y[62:52]) && (|r_y[51:0]);
        x_inf  = (&r_x[62:52]) && !(|r_x[51:0]);
        y_inf  = (&r_y[62:52]) && !(|r_y[51:0]);
        x_zero = (r_x[62:0] == '0);
        y_zero = (r_y[62:0] == '0);
    end

    always_comb begin
        case (r_op)
            OP_TSUB: begin opa = r_prod; opb = r_comp; sub_op = 1'b1; end
            OP_SADD: begin opa = r_sum;  opb = r_term; sub_op = 1'b0; end
            OP_DSUB: begin opa = r_next; opb = r_sum;  sub_op = 1'b1; end
            OP_CSUB: begin opa = r_diff; opb = r_term; sub_op = 1'b1; end
            default: begin opa = '0;     opb = '0;     sub_op = 1'b0; end
        endcase
        bb      = {opb[63] ^ sub_op, opb[62:0]};
        swap    = (bb[62:0] > opa[62:0]);
        lg      = swap ? bb : opa;
        sm      = swap ? opa : bb;
        a_nan   = (&opa[62:52]) && (|opa[51:0]);
        b_nan   = (&bb[62:52]) && (|bb[51:0]);
        a_inf   = (&opa[62:52]) && !(|opa[51:0]);
        b_inf   = (&bb[62:52]) && !(|bb[51:0]);
        el      = (lg[62:52] == '0) ? 11'd1 : lg[62:52];
        es      = (sm[62:52] == '0) ? 11'd1 : sm[62:52];
        dd      = el - es;
        ms_full = {1'b0, |sm[62:52], sm[51:0], 52'd0};
        if (dd >= 11'd106) begin
            ms_al = {105'd0, |ms_full};
        end else begin
            ms_al = (ms_full >> dd[6:0])
                  | {105'd0, |(ms_full & ((106'd1 << dd[6:0]) - 106'd1))};
        end
        add_m = r_al_sub ? (r_al_ml - r_al_ms) : (r_al_ml + r_al_ms);
    end

    always_comb begin
        rnd_req = '0;
        if (r_state == S_MULF) begin
            rnd_req.valid = 1'b1;
            rnd_req.sign  = r_x[63] ^ r_y[63];
            rnd_req.expo  = {3'd0, xe} + {3'd0, ye} - 14'd1023;
            rnd_req.mant  = r_acc;
            if (x_nan || y_nan || (x_inf && y_zero) || (y_inf && x_zero)) begin
                rnd_req.spec      = 1'b1;
                rnd_req.spec_bits = CANON_NAN;
            end else if (x_inf || y_inf) begin
                rnd_req.spec      = 1'b1;
                rnd_req.spec_bits = {r_x[63] ^ r_y[63], 11'h7FF, 52'd0};
            end else if (x_zero || y_zero) begin
                rnd_req.spec      = 1'b1;
                rnd_req.spec_bits = {r_x[63] ^ r_y[63], 63'd0};
            end
        end else if (r_state == S_ADD) begin
            rnd_req.valid     = 1'b1;
            rnd_req.sign      = (add_m == '0) ? r_al_zsign : r_al_sign;
            rnd_req.expo      = {3'd0, r_al_e};
            rnd_req.mant      = add_m;
            rnd_req.spec      = r_al_spec;
            rnd_req.spec_bits = r_al_spec_bits;
        end
    end

    assign emit_bits = ((&r_sum[62:52]) && (|r_sum[51:0])) ? CANON_NAN : r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_MUL;
            r_k     <= '0;
            r_sum   <= '0;
            r_comp  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_out_ready && (r_state != S_EMIT)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_x     <= i_item.x_bits;
                        r_y     <= i_item.y_bits;
                        r_last  <= i_item.last_element;
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_op    <= OP_MUL;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc <= r_acc + ({52'd0, pp} << pshift);
                    r_k   <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_state <= S_MULF;
                    end
                end
                S_MULF: begin
                    r_state <= S_WAIT;
                end
                S_ALIGN: begin
                    r_al_sign  <= lg[63];
                    r_al_zsign <= lg[63] & sm[63];
                    r_al_sub   <= lg[63] ^ sm[63];
                    r_al_e     <= el;
                    r_al_ml    <= {1'b0, |lg[62:52], lg[51:0], 52'd0};
                    r_al_ms    <= ms_al;
                    r_al_spec  <= a_nan || b_nan || a_inf || b_inf;
                    if (a_nan || b_nan || (a_inf && b_inf && (opa[63] != bb[63]))) begin
                        r_al_spec_bits <= CANON_NAN;
                    end else if (a_inf) begin
                        r_al_spec_bits <= {opa[63], 11'h7FF, 52'd0};
                    end else begin
                        r_al_spec_bits <= {bb[63], 11'h7FF, 52'd0};
                    end
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (rnd_valid) begin
                        case (r_op)
                            OP_MUL:  r_prod <= rnd_bits;
                            OP_TSUB: r_term <= rnd_bits;
                            OP_SADD: r_next <= rnd_bits;
                            OP_DSUB: r_diff <= rnd_bits;
                            default: begin
                                r_comp <= rnd_bits;
                                r_sum  <= r_next;
                            end
                        endcase
                        if (r_op == OP_CSUB) begin
                            r_state <= r_last ? S_EMIT : S_IDLE;
                        end else begin
                            r_op    <= r_op + 1'b1;
                            r_state <= S_ALIGN;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov    <= 1'b1;
                        r_ob    <= emit_bits;
                        r_sum   <= '0;
                        r_comp  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_item_ready     = (r_state == S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_out_bits       = r_ob;
    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.item_last = r_last;

endmodule

`default_nettype wire

[rtl/kahan_compensated_dot_product_unit.sv]
// Kahan-compensated binary64 dot product.
// The back end takes a new item only when it has finished the last one: it
// runs five dependent rounded operations, the product on one iterative
// multiplier and all five through one 4-stage rounder.
// The input queue takes QUEUE_DEPTH items while the back end works.
// Reset (i_rst_n low, synchronous) empties the queue, sum and compensation to +0.
`default_nettype none

`include "kahan_compensated_dot_product_unit_macros.svh"

module kahan_compensated_dot_product_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    kcdp_in_if.sink     i_in,
    kcdp_out_if.source  o_out
);
    import kcdp_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item           in_item;
    t_item           q_item;
    logic            q_valid;
    logic            q_pop_ready;
    logic            q_pop;
    logic [CW - 1:0] q_count;
    t_back_stat      bstat;

    assign in_item.x_bits       = i_in.x_bits;
    assign in_item.y_bits       = i_in.y_bits;
    assign in_item.last_element = i_in.last_element;
    assign q_pop                = q_valid && q_pop_ready;

    kcdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_item),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .o_item  (q_item),
        .o_valid (q_valid),
        .i_ready (q_pop_ready),
        .o_count (q_count)
    );

    kcdp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_item_valid (q_valid),
        .o_item_ready (q_pop_ready),
        .o_out_valid  (o_out.valid),
        .o_out_bits   (o_out.dot_bits),
        .i_out_ready  (o_out.ready),
        .o_stat       (bstat)
    );

    `KCDP_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= CW'(QUEUE_DEPTH), "queue overfilled")
    `KCDP_ASSERT_NOW(a_pop_idle, q_pop, bstat.idle, "transfer to back end while busy")
    `KCDP_ASSERT_NEXT(a_pop_busy, q_pop, !bstat.idle, "back end did not start item")

endmodule

`default_nettype wire

[dv/kahan_compensated_dot_product_unit_tb.sv]
`timescale 1ns / 100ps
`default_nettype none

module kahan_compensated_dot_product_unit_tb;
    import kcdp_pkg::*;

    class dot_scoreboard;
        real         acc_sum;
        real         acc_comp;
        logic [63:0] dot_q[$];
        bit          failed;

        function new();
            acc_sum  = $bitstoreal(64'h0);
            acc_comp = $bitstoreal(64'h0);
            failed   = 0;
        endfunction

        // each step rounded on its own, no fused multiply-add
        function void note_transfer(logic [63:0] x, logic [63:0] y, logic last);
            real prod;
            real term;
            real nxt;
            real diff;
            logic [63:0] b;
            prod     = $bitstoreal(x) * $bitstoreal(y);
            term     = prod - acc_comp;
            nxt      = acc_sum + term;
            diff     = nxt - acc_sum;
            acc_comp = diff - term;
            acc_sum  = nxt;
            if (last) begin
                b = $realtobits(acc_sum);
                if (b[62:52] == 11'h7FF && b[51:0] != 52'h0) b = CANON_NAN;
                dot_q.push_back(b);
                acc_sum  = $bitstoreal(64'h0);
                acc_comp = $bitstoreal(64'h0);
            end
        endfunction

        function void check_result(logic [63:0] dot);
            logic [63:0] want;
            if (dot_q.size() == 0) begin
                $error("unexpected result: dot_bits %h", dot);
                failed = 1;
            end else begin
                want = dot_q.pop_front();
                if (dot !== want) begin
                    $error("dot_bits expected %h actual %h", want, dot);
                    failed = 1;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   hold_req;
    int   hold_done;
    int   hold_left;
    dot_scoreboard sb;

    kcdp_in_if  in_if();
    kcdp_out_if out_if();

    kahan_compensated_dot_product_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && in_if.valid && in_if.ready)
            sb.note_transfer(in_if.x_bits, in_if.y_bits, in_if.last_element);
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.dot_bits);
    end

    // receiver, with long hold-offs on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req != hold_done) begin
            out_if.ready <= 1'b0;
            hold_done = hold_done + 1;
            hold_left = 600;
        end else begin
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_pair(input logic [63:0] x, input logic [63:0] y, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid        <= 1'b1;
        in_if.x_bits       <= x;
        in_if.y_bits       <= y;
        in_if.last_element <= last;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.dot_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_f64();
        logic [63:0] v;
        int k;
        k = $urandom_range(99);
        v = {$urandom, $urandom};
        if (k < 55) begin
            v[62:52] = 11'(1023 + $urandom_range(40) - 20);
        end else if (k < 65) begin
            v[62:52] = 11'(1023 + $urandom_range(4) - 2);
            v[51:30] = '0;
        end else if (k < 72) begin
            v[62:52] = 11'h0;
        end else if (k < 78) begin
            v[62:0] = (k < 75) ? 63'h0 : {11'h7FF, 52'h0};
        end else if (k < 80) begin
            v[62:52] = 11'h7FF;
        end else if (k < 85) begin
            v[62:52] = ($urandom_range(1)) ? 11'h7FE : 11'h001;
        end
        return v;
    endfunction

    task automatic send_vectors(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                // noise: lone pairs with random flags
                send_pair(rand_f64(), rand_f64(), 1'($urandom_range(1)));
                sent++;
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_pair(rand_f64(), rand_f64(), i == len - 1);
                sent += len;
            end
        end
    endtask

    initial begin
        sb                 = new();
        rst_n              = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;
        hold_req           = 0;
        hold_done          = 0;
        hold_left          = 0;
        in_if.valid        = 1'b0;
        in_if.x_bits       = '0;
        in_if.y_bits       = '0;
        in_if.last_element = 1'b0;
        out_if.ready       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_pair(64'h0, 64'h0, 1'b1);
        send_pair(64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
        send_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
        send_pair(64'h3CA0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
        send_pair(64'h3CA0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
        send_pair(64'h7FF0_0000_0000_0000, 64'h0, 1'b1);
        send_pair(64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
        send_pair(64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
        send_pair(64'h7FF0_0000_0000_0000, 64'hC000_0000_0000_0000, 1'b1);
        send_pair(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1);
        send_pair(64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000, 1'b0);
        send_pair(64'h000F_FFFF_FFFF_FFFF, 64'h3FE0_0000_0000_0000, 1'b1);
        send_pair(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001, 1'b1);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 1'b1);
        send_pair(64'h7FF0_0000_0000_0001, 64'h0, 1'b0);
        send_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
        send_pair(64'h4340_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
        send_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
        send_pair(64'hC340_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
        send_pair(64'hFFEF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 1'b1);
        drain();

        send_vectors(200);
        drain();
        idle_pct = 84;
        send_vectors(200);
        drain();
        idle_pct  = 0;
        stall_pct = 84;
        send_vectors(200);
        drain();
        idle_pct  = 29;
        stall_pct = 29;
        send_vectors(100);
        hold_req = hold_req + 1;
        idle_pct = 0;
        send_vectors(100);
        drain();

        if (!sb.failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire
